// ===== design/rut_pkg.sv =====
// Shared types and constants for the retransmit table.
// No dependencies; every other file of the block but rut_ram imports this package.
package rut_pkg;

  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int LIMIT_W  = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input opcodes; the fourth code is unused and ignored
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_LIMIT    = 1'b1;

  localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 8'd5;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_LOAD,
    ST_SEND,
    ST_DROP,
    ST_MATCH,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_op;
    logic       add_write;
    logic       ram_rd;
    logic       load_cur;
    logic       upd_send;
    logic       write_cur;
    logic       adv_rd;
    logic       set_found;
    logic       push;
    logic [1:0] push_kind;
    logic       flush;
    logic       commit_count;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       rd_last;
    logic       send_due;
    logic       drop_due;
    logic       id_match;
    logic       found;
    logic       pend_valid;
    logic       push_ok;
    logic       out_free;
  } sts_t;

endpackage

// ===== design/rut_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
// Depends on rut_pkg for field widths.
interface rut_in_if import rut_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ID_W-1:0]     entry_id;
  logic [HANDLE_W-1:0] msg_handle;
  logic [TIME_W-1:0]   now;

  modport source (output valid, opcode, entry_id, msg_handle, now, input ready);
  modport sink (input valid, opcode, entry_id, msg_handle, now, output ready);
endinterface

interface rut_out_if import rut_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [ID_W-1:0]     out_id;
  logic [HANDLE_W-1:0] out_handle;
  logic                last;

  modport source (output valid, kind, out_id, out_handle, last, input ready);
  modport sink (input valid, kind, out_id, out_handle, last, output ready);
endinterface

// ===== design/rut_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WIDTH-1:0]     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== design/rut_dp.sv =====
// Datapath: entry table RAM, walk pointers, current entry, pending and output beats.
// Depends on rut_pkg and rut_ram.
module rut_dp import rut_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          in_opcode,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [HANDLE_W-1:0] in_msg_handle,
  input  logic [TIME_W-1:0]   in_now,
  input  logic [TIME_W-1:0]   resend_interval,
  input  logic [LIMIT_W-1:0]  max_resends,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [ID_W-1:0]     out_id,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                out_last
);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Control state
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic             found_r, found_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state
  logic [1:0]          op_r;
  logic [ID_W-1:0]     op_id_r;
  logic [HANDLE_W-1:0] op_handle_r;
  logic [TIME_W-1:0]   op_now_r;
  entry_t              cur_r;
  logic [1:0]          pend_kind_r;
  logic [ID_W-1:0]     pend_id_r;
  logic [HANDLE_W-1:0] pend_handle_r;
  logic [1:0]          out_kind_r;
  logic [ID_W-1:0]     out_id_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_last_r;

  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  entry_t              ram_wr_data;
  logic [ENTRY_W-1:0]  ram_rd_data;
  logic [TIME_W-1:0]   elapsed;
  logic                out_free;
  logic [ID_W-1:0]     new_id;
  logic [HANDLE_W-1:0] new_handle;

  // Table storage; a new entry lands at the fill count, kept ones compact at wr
  always_comb begin
    ram_wr_en = cmd.add_write | cmd.write_cur;
    if (cmd.add_write) begin
      ram_wr_addr        = n_r[IDX_W-1:0];
      ram_wr_data.id     = op_id_r;
      ram_wr_data.handle = op_handle_r;
      ram_wr_data.stamp  = op_now_r;
      ram_wr_data.count  = '0;
    end else begin
      ram_wr_addr = wr_r[IDX_W-1:0];
      ram_wr_data = cur_r;
    end
  end

  rut_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.ram_rd),
    .rd_addr (rd_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Status toward the controller
  assign elapsed  = op_now_r - cur_r.stamp;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts.in_op      = in_opcode;
    sts.op         = op_r;
    sts.full       = (n_r == CNT_W'(TABLE_DEPTH));
    sts.empty      = (n_r == '0);
    sts.rd_last    = ((rd_r + CNT_W'(1)) == n_r);
    sts.send_due   = (cur_r.count == '0) || (elapsed > resend_interval);
    sts.drop_due   = (cur_r.count > {1'b0, max_resends});
    sts.id_match   = (cur_r.id == op_id_r);
    sts.found      = found_r;
    sts.pend_valid = pend_valid_r;
    sts.push_ok    = !pend_valid_r || out_free;
    sts.out_free   = out_free;
  end

  // Next control state
  always_comb begin
    n_nxt          = n_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.latch_op) begin
      rd_nxt    = '0;
      wr_nxt    = '0;
      found_nxt = 1'b0;
    end
    if (cmd.add_write) begin
      n_nxt = n_r + CNT_W'(1);
    end
    if (cmd.commit_count) begin
      n_nxt = wr_r;
    end
    if (cmd.adv_rd) begin
      rd_nxt = rd_r + CNT_W'(1);
    end
    if (cmd.write_cur) begin
      wr_nxt = wr_r + CNT_W'(1);
    end
    if (cmd.set_found) begin
      found_nxt = 1'b1;
    end
    // A new result parks in pend; the previous one moves out as a non-final beat
    if (cmd.push) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
      end
      pend_valid_nxt = 1'b1;
    end
    // End of item: the parked result leaves as the final beat
    if (cmd.flush && pend_valid_r) begin
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      rd_r         <= '0;
      wr_r         <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      n_r          <= n_nxt;
      rd_r         <= rd_nxt;
      wr_r         <= wr_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result source: the rejected item for a full table, else the current entry
  assign new_id     = (cmd.push_kind == KIND_FULL) ? op_id_r : cur_r.id;
  assign new_handle = (cmd.push_kind == KIND_FULL) ? op_handle_r : cur_r.handle;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_r        <= in_opcode;
      op_id_r     <= in_entry_id;
      op_handle_r <= in_msg_handle;
      op_now_r    <= in_now;
    end
    if (cmd.load_cur) begin
      cur_r <= entry_t'(ram_rd_data);
    end else if (cmd.upd_send) begin
      cur_r.stamp <= op_now_r;
      if (cur_r.count != COUNT_MAX) begin
        cur_r.count <= cur_r.count + COUNT_W'(1);
      end
    end
    if (cmd.push) begin
      if (pend_valid_r) begin
        out_kind_r   <= pend_kind_r;
        out_id_r     <= pend_id_r;
        out_handle_r <= pend_handle_r;
        out_last_r   <= 1'b0;
      end
      pend_kind_r   <= cmd.push_kind;
      pend_id_r     <= new_id;
      pend_handle_r <= new_handle;
    end
    if (cmd.flush && pend_valid_r) begin
      out_kind_r   <= pend_kind_r;
      out_id_r     <= pend_id_r;
      out_handle_r <= pend_handle_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_id     = out_id_r;
  assign out_handle = out_handle_r;
  assign out_last   = out_last_r;

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && pend_valid_r |-> out_free)
    else $error("result pushed while output beat still occupied");
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_cur |-> wr_r <= rd_r)
    else $error("compaction pointer overtook read pointer");
  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_write |-> n_r < CNT_W'(TABLE_DEPTH))
    else $error("entry written into a full table");
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush && pend_valid_r |=> out_valid_r && out_last_r)
    else $error("final beat not marked last");
`endif
endmodule

// ===== design/rut_ctrl.sv =====
// Controller: sequences add, acknowledge and tick walks over the entry table.
// Depends on rut_pkg.
module rut_ctrl import rut_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      // Take one item and pick its flow
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_op = 1'b1;
          if (sts.in_op == OP_ADD) begin
            state_nxt = ST_ADD;
          end else if (sts.in_op == OP_ACK || sts.in_op == OP_TICK) begin
            state_nxt = sts.empty ? ST_FLUSH : ST_READ;
          end
        end
      end
      // Append, or reject on a full table
      ST_ADD: begin
        if (sts.full) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_FULL;
          state_nxt     = ST_FLUSH;
        end else begin
          cmd.add_write = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_cur = 1'b1;
        state_nxt    = (sts.op == OP_TICK) ? ST_SEND : ST_MATCH;
      end
      // Resend a due entry and stamp it
      ST_SEND: begin
        if (!sts.send_due) begin
          state_nxt = ST_DROP;
        end else if (sts.push_ok) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_SEND;
          cmd.upd_send  = 1'b1;
          state_nxt     = ST_DROP;
        end
      end
      // Drop an entry past its retry limit, else keep it, compacted down
      ST_DROP: begin
        if (!sts.drop_due) begin
          cmd.write_cur = 1'b1;
          cmd.adv_rd    = 1'b1;
          state_nxt     = sts.rd_last ? ST_FLUSH : ST_READ;
        end else if (sts.push_ok) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_RELEASE;
          cmd.adv_rd    = 1'b1;
          state_nxt     = sts.rd_last ? ST_FLUSH : ST_READ;
        end
      end
      // Remove the oldest entry with the acknowledged id, shift the rest down
      ST_MATCH: begin
        if (sts.found || !sts.id_match) begin
          cmd.write_cur = 1'b1;
          cmd.adv_rd    = 1'b1;
          state_nxt     = sts.rd_last ? ST_FLUSH : ST_READ;
        end else if (sts.push_ok) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_RELEASE;
          cmd.set_found = 1'b1;
          cmd.adv_rd    = 1'b1;
          state_nxt     = sts.rd_last ? ST_FLUSH : ST_READ;
        end
      end
      // Release the final beat and settle the fill count
      ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.flush        = 1'b1;
          cmd.commit_count = (sts.op != OP_ADD);
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !sts.pend_valid)
    else $error("idle with a result still parked");
  a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_LOAD)
    else $error("table read not followed by load");
  a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && !sts.pend_valid |=> state_r == ST_IDLE)
    else $error("flush with nothing parked did not return to idle");
`endif
endmodule

// ===== design/retransmit_until_ack_table.sv =====
// Retransmit table: pending messages with acknowledge and retry limit.
// Channels: in_ch takes one item per beat (opcode add/ack/tick, id, handle,
// now); out_ch gives result beats (send, release, table full), the final
// beat of an item carrying last. Configuration goes through an APB-style
// port: resend_interval at 0x0, max_resends at 0x4; pready is always high.
// Flow per item: in_ch is ready only between items.
//   add: append; on a full table, reject and flush, plus output stall.
//   ack: read, load and match per stored entry (every entry is visited so later
//        entries shift down after the removed one).
//   tick: read, load, resend check and drop check per stored entry,
//        all through the single read port of the table RAM.
// Each result is held one beat back until the next is known, so last is
// exact; the output register lets the next item start while a beat waits.
// Reset empties the table (fill count zero) and restores the registers.
// When out_ch stalls, the walk holds at the entry whose result is blocked.
// Depends on rut_pkg, rut_if, rut_ram, rut_dp and rut_ctrl.
module retransmit_until_ack_table import rut_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rut_in_if.sink            in_ch,
  rut_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);
  logic [TIME_W-1:0]  resend_interval_r;
  logic [LIMIT_W-1:0] max_resends_r;
  logic               cfg_wr;
  logic               cfg_sel;
  cmd_t               cmd;
  sts_t               sts;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_interval_r <= INTERVAL_RESET;
      max_resends_r     <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_INTERVAL: resend_interval_r <= cfg_pwdata;
        REG_LIMIT:    max_resends_r     <= cfg_pwdata[LIMIT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_INTERVAL: cfg_prdata = resend_interval_r;
      REG_LIMIT:    cfg_prdata = {{(CFG_DW-LIMIT_W){1'b0}}, max_resends_r};
      default:      cfg_prdata = '0;
    endcase
  end

  rut_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rut_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_entry_id     (in_ch.entry_id),
    .in_msg_handle   (in_ch.msg_handle),
    .in_now          (in_ch.now),
    .resend_interval (resend_interval_r),
    .max_resends     (max_resends_r),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_id          (out_ch.out_id),
    .out_handle      (out_ch.out_handle),
    .out_last        (out_ch.last)
  );
endmodule
